/* hdl/load_level_hysteresis_monitor_macros.svh */
// Assertion macros shared by the load level monitor RTL.
`ifndef LOAD_LEVEL_HYSTERESIS_MONITOR_MACROS_SVH
`define LOAD_LEVEL_HYSTERESIS_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLHM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llhm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llhm: next-cycle check failed");

`endif

/* hdl/llhm_pkg.sv */
// Shared constants, register codes and types of the load level monitor.
package llhm_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int WL_W             = 6;
  localparam int LEVEL_W          = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int PROD_W           = 32;
  localparam int WINDOW_MAX_DEF   = 32;
  localparam int PERCENT_MODE_DEF = 0;

  localparam logic [WL_W-1:0] DEFAULT_WINDOW = 6'd20;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FATAL_RELEASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_RELEASE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_RELEASE  = 3'd7;

  localparam logic [LEVEL_W-1:0] LVL_IDLE  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ERROR = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_FATAL = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] base_level;
    logic [SAMPLE_W-1:0] error_level;
    logic [SAMPLE_W-1:0] warn_level;
    logic [SAMPLE_W-1:0] idle_level;
    logic [SAMPLE_W-1:0] fatal_release;
    logic [SAMPLE_W-1:0] error_release;
    logic [SAMPLE_W-1:0] warn_release;
  } thr_cfg_t;

endpackage

/* hdl/llhm_window.sv */
// Sample window memory with fill count, oldest pointer and running sum.
module llhm_window #(
  parameter int WINDOW_MAX = llhm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          clear,
  input  logic                                          start,
  input  logic [llhm_pkg::SAMPLE_W-1:0]                 sample,
  input  logic [llhm_pkg::WL_W-1:0]                     n,
  output logic                                          done,
  output logic [llhm_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] sum
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int SUM_W = llhm_pkg::SAMPLE_W + PTR_W;
  localparam int XW    = (PTR_W + 1 > llhm_pkg::WL_W) ? PTR_W + 1 : llhm_pkg::WL_W;

  logic [llhm_pkg::SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic [llhm_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [llhm_pkg::SAMPLE_W-1:0] smp_r;
  logic [llhm_pkg::WL_W-1:0]     fill_r;
  logic [llhm_pkg::WL_W-1:0]     fill_nxt;
  logic [PTR_W-1:0]              oldest_r;
  logic [PTR_W-1:0]              oldest_nxt;
  logic [SUM_W-1:0]              sum_r;
  logic [SUM_W-1:0]              sum_nxt;
  logic                          busy_r;
  logic                          done_r;
  logic                          full;
  logic [PTR_W-1:0]              wr_addr;

  assign full    = (fill_r == n);
  assign wr_addr = full ? oldest_r : PTR_W'(fill_r);

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    sum_nxt    = sum_r + SUM_W'(smp_r);
    if (full) begin
      sum_nxt = sum_r - SUM_W'(rd_data_r) + SUM_W'(smp_r);
      if (XW'(oldest_r) + XW'(1) == XW'(n)) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_r + PTR_W'(1);
      end
    end else begin
      fill_nxt = fill_r + llhm_pkg::WL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[oldest_r];
    if (busy_r) begin
      mem[wr_addr] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      smp_r <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
      sum_r    <= '0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= busy_r;
      if (clear) begin
        fill_r   <= '0;
        oldest_r <= '0;
        sum_r    <= '0;
        busy_r   <= 1'b0;
      end else if (busy_r) begin
        fill_r   <= fill_nxt;
        oldest_r <= oldest_nxt;
        sum_r    <= sum_nxt;
        busy_r   <= 1'b0;
      end else if (start) begin
        busy_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

/* hdl/llhm_divider.sv */
// Bit-serial restoring divider of the window sum by the window length.
module llhm_divider #(
  parameter int WINDOW_MAX = llhm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [llhm_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] dividend,
  input  logic [llhm_pkg::WL_W-1:0]                     divisor,
  output logic                                          done,
  output logic [llhm_pkg::SAMPLE_W-1:0]                 quotient
);

  localparam int SUM_W = llhm_pkg::SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int RW    = llhm_pkg::WL_W;

  logic [SUM_W-1:0] dq_r;
  logic [RW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             ge;

  assign trial = {rem_r, dq_r[SUM_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[RW-1:0] : trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (start) begin
        cnt_r  <= CNT_W'(SUM_W);
        busy_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r[llhm_pkg::SAMPLE_W-1:0];

endmodule

/* hdl/llhm_level.sv */
// Threshold compare sequencer and hysteresis level register.
module llhm_level #(
  parameter int PERCENT_MODE = llhm_pkg::PERCENT_MODE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [llhm_pkg::SAMPLE_W-1:0] avg,
  input  llhm_pkg::thr_cfg_t            thr,
  output logic                          done,
  output logic [llhm_pkg::LEVEL_W-1:0]  level,
  output logic                          changed
);

  localparam int SW = llhm_pkg::SAMPLE_W;
  localparam int PW = llhm_pkg::PROD_W;

  localparam logic [2:0] STEP_ERR   = 3'd0;
  localparam logic [2:0] STEP_WARN  = 3'd1;
  localparam logic [2:0] STEP_IDLE  = 3'd2;
  localparam logic [2:0] STEP_REL   = 3'd3;
  localparam logic [2:0] STEP_LAST  = 3'd4;
  localparam logic [2:0] STEP_DEC   = 3'd5;

  logic [2:0]                     step_r;
  logic                           busy_r;
  logic                           done_r;
  logic [SW-1:0]                  avg_r;
  logic [PW-1:0]                  prod_r;
  logic [3:0]                     flags_r;
  logic [llhm_pkg::LEVEL_W-1:0]   level_r;
  logic [llhm_pkg::LEVEL_W-1:0]   level_nxt;
  logic                           changed_r;
  logic [SW-1:0]                  sel;
  logic [SW-1:0]                  rel;
  logic [PW-1:0]                  thr_val;
  logic                           gt;

  always_comb begin
    case (level_r)
      llhm_pkg::LVL_WARN:  rel = thr.warn_release;
      llhm_pkg::LVL_ERROR: rel = thr.error_release;
      llhm_pkg::LVL_FATAL: rel = thr.fatal_release;
      default:             rel = '0;
    endcase
  end

  always_comb begin
    case (step_r)
      STEP_ERR:  sel = thr.error_level;
      STEP_WARN: sel = thr.warn_level;
      STEP_IDLE: sel = thr.idle_level;
      STEP_REL:  sel = rel;
      default:   sel = '0;
    endcase
  end

  assign thr_val = (PERCENT_MODE != 0) ? PW'(thr.base_level) * PW'(sel) : {sel, SW'(0)};
  assign gt      = ({avg_r, SW'(0)} > prod_r);

  // Flags hold: above error, above warn, above idle, at or below release.
  always_comb begin
    level_nxt = level_r;
    case (level_r)
      llhm_pkg::LVL_IDLE: begin
        if (flags_r[0]) level_nxt = llhm_pkg::LVL_FATAL;
        else if (flags_r[1]) level_nxt = llhm_pkg::LVL_ERROR;
        else if (flags_r[2]) level_nxt = llhm_pkg::LVL_WARN;
      end
      llhm_pkg::LVL_WARN: begin
        if (flags_r[0]) level_nxt = llhm_pkg::LVL_FATAL;
        else if (flags_r[1]) level_nxt = llhm_pkg::LVL_ERROR;
        else if (flags_r[3]) level_nxt = llhm_pkg::LVL_IDLE;
      end
      llhm_pkg::LVL_ERROR: begin
        if (flags_r[0]) level_nxt = llhm_pkg::LVL_FATAL;
        else if (flags_r[3]) level_nxt = llhm_pkg::LVL_IDLE;
      end
      default: begin
        if (flags_r[3]) level_nxt = llhm_pkg::LVL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      avg_r <= avg;
    end
    if (busy_r) begin
      prod_r <= thr_val;
      case (step_r)
        STEP_WARN: flags_r[0] <= gt;
        STEP_IDLE: flags_r[1] <= gt;
        STEP_REL:  flags_r[2] <= gt;
        STEP_LAST: flags_r[3] <= !gt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_ERR;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      level_r   <= llhm_pkg::LVL_IDLE;
      changed_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (step_r == STEP_DEC) begin
          level_r   <= level_nxt;
          changed_r <= (level_nxt != level_r);
          busy_r    <= 1'b0;
          done_r    <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end else if (start) begin
        step_r <= STEP_ERR;
        busy_r <= 1'b1;
      end
    end
  end

  assign done    = done_r;
  assign level   = level_r;
  assign changed = changed_r;

endmodule

/* hdl/load_level_hysteresis_monitor.sv */
// Load level monitor top level: moving average of samples with hysteresis levels.
// One item at a time: an accepted item passes the window, the bit-serial divider, the
// level sequencer and the output register, and in_stall is high until it is through.
// An item ignored while base_level is zero goes straight to the output register.
// Synchronous active-low reset clears the window, the level (idle), the thresholds and
// the last average and loads the default window length; window memory is not cleared.
`include "load_level_hysteresis_monitor_macros.svh"

module load_level_hysteresis_monitor #(
  parameter int WINDOW_MAX   = llhm_pkg::WINDOW_MAX_DEF,
  parameter int PERCENT_MODE = llhm_pkg::PERCENT_MODE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [llhm_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [llhm_pkg::LEVEL_W-1:0]    out_level,
  output logic                            out_changed,
  output logic [llhm_pkg::SAMPLE_W-1:0]   out_average,
  input  logic                            cfg_we,
  input  logic [llhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llhm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = llhm_pkg::SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int WL_W  = llhm_pkg::WL_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WIN  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_LVL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                     state_r;
  logic [2:0]                     state_nxt;
  logic [WL_W-1:0]                wl_r;
  llhm_pkg::thr_cfg_t             thr_r;
  logic [WL_W-1:0]                n;
  logic                           accept;
  logic                           go;
  logic                           clear;
  logic                           win_done;
  logic [SUM_W-1:0]               win_sum;
  logic                           div_done;
  logic [llhm_pkg::SAMPLE_W-1:0]  quot;
  logic                           lvl_done;
  logic [llhm_pkg::LEVEL_W-1:0]   lvl_level;
  logic                           lvl_changed;
  logic [llhm_pkg::SAMPLE_W-1:0]  last_avg_r;
  logic [llhm_pkg::LEVEL_W-1:0]   res_level_r;
  logic                           res_changed_r;
  logic                           out_valid_r;
  logic [llhm_pkg::LEVEL_W-1:0]   out_level_r;
  logic                           out_changed_r;
  logic [llhm_pkg::SAMPLE_W-1:0]  out_average_r;
  logic                           out_free;

  always_comb begin
    if (wl_r == '0) begin
      n = WL_W'(1);
    end else if (int'(wl_r) > WINDOW_MAX) begin
      n = WL_W'(WINDOW_MAX);
    end else begin
      n = wl_r;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign go       = accept && (thr_r.base_level != '0);
  assign clear    = cfg_we && (cfg_index == llhm_pkg::REG_WINDOW_LENGTH);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= llhm_pkg::DEFAULT_WINDOW;
      thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        llhm_pkg::REG_WINDOW_LENGTH: wl_r                <= cfg_wdata[WL_W-1:0];
        llhm_pkg::REG_BASE_LEVEL:    thr_r.base_level    <= cfg_wdata;
        llhm_pkg::REG_ERROR_LEVEL:   thr_r.error_level   <= cfg_wdata;
        llhm_pkg::REG_WARN_LEVEL:    thr_r.warn_level    <= cfg_wdata;
        llhm_pkg::REG_IDLE_LEVEL:    thr_r.idle_level    <= cfg_wdata;
        llhm_pkg::REG_FATAL_RELEASE: thr_r.fatal_release <= cfg_wdata;
        llhm_pkg::REG_ERROR_RELEASE: thr_r.error_release <= cfg_wdata;
        llhm_pkg::REG_WARN_RELEASE:  thr_r.warn_release  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  llhm_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .start  (go),
    .sample (in_sample),
    .n      (n),
    .done   (win_done),
    .sum    (win_sum)
  );

  llhm_divider #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (win_done),
    .dividend (win_sum),
    .divisor  (n),
    .done     (div_done),
    .quotient (quot)
  );

  llhm_level #(
    .PERCENT_MODE (PERCENT_MODE)
  ) u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_done),
    .avg     (quot),
    .thr     (thr_r),
    .done    (lvl_done),
    .level   (lvl_level),
    .changed (lvl_changed)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go) state_nxt = ST_WIN;
        else if (accept) state_nxt = ST_OUT;
      end
      ST_WIN:  if (win_done) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_LVL;
      ST_LVL:  if (lvl_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && !go) begin
      res_level_r   <= lvl_level;
      res_changed_r <= 1'b0;
    end else if (state_r == ST_LVL && lvl_done) begin
      res_level_r   <= lvl_level;
      res_changed_r <= lvl_changed;
    end
    if (state_r == ST_OUT && out_free) begin
      out_level_r   <= res_level_r;
      out_changed_r <= res_changed_r;
      out_average_r <= last_avg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_avg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_done) begin
        last_avg_r <= quot;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_changed = out_changed_r;
  assign out_average = out_average_r;

  `LLHM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, state_r != ST_IDLE)
  `LLHM_ASSERT_IMPL(a_win_done_in_win, clk, rst_n, win_done, state_r == ST_WIN)
  `LLHM_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_done, state_r == ST_DIV)
  `LLHM_ASSERT_IMPL(a_lvl_done_in_lvl, clk, rst_n, lvl_done, state_r == ST_LVL)

endmodule

/* dv/load_level_hysteresis_monitor_tb.sv */
// Self-checking testbench for the load level monitor: moving average and level hysteresis.
module load_level_hysteresis_monitor_tb;

  localparam int WIN_MAX  = llhm_pkg::WINDOW_MAX_DEF;
  localparam int PCT_MODE = llhm_pkg::PERCENT_MODE_DEF;
  localparam int N_PHASES = 10;
  localparam int SETTLE   = 40;
  localparam int SW       = llhm_pkg::SAMPLE_W;
  localparam int LW       = llhm_pkg::LEVEL_W;

  localparam logic [15:0] STEP_SAMPLES [20] = '{
    16'd0, 16'hFFFF, 16'd2600, 16'd2500, 16'd1500, 16'd2500, 16'd1600, 16'd1500,
    16'd1200, 16'd800, 16'd500, 16'd2500, 16'd3500, 16'd0, 16'd1100, 16'd3100,
    16'd100, 16'h5555, 16'hAAAA, 16'hFFFF
  };
  localparam logic [15:0] WL_CHOICE [N_PHASES] = '{
    16'd4, 16'd0, 16'd32, 16'd63, 16'd0, 16'hFFC3, 16'd0, 16'd1, 16'd40, 16'd2
  };

  typedef struct packed {
    logic [LW-1:0] level;
    logic          changed;
    logic [SW-1:0] average;
  } load_report_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [SW-1:0]                   in_sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [LW-1:0]                   out_level;
  logic                            out_changed;
  logic [SW-1:0]                   out_average;
  logic                            cfg_we = 1'b0;
  logic [llhm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [llhm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  load_level_hysteresis_monitor #(
    .WINDOW_MAX  (WIN_MAX),
    .PERCENT_MODE(PCT_MODE)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_level  (out_level),
    .out_changed(out_changed),
    .out_average(out_average),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  logic [SW-1:0] sample_q [$];
  load_report_t  pending_reports [$];

  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_go = 1'b0;
  logic hold_on = 1'b0;
  int  err_cnt = 0;
  int  sample_cnt = 0;
  int  unarmed_cnt = 0;
  int  report_cnt = 0;
  int  change_cnt = 0;
  int  level_seen [4] = '{0, 0, 0, 0};

  // Mirror of the registers and the averaging window.
  logic [llhm_pkg::WL_W-1:0] wl_reg = llhm_pkg::DEFAULT_WINDOW;
  llhm_pkg::thr_cfg_t        thr_cfg = '0;
  logic [SW-1:0]             win_mem [WIN_MAX];
  int unsigned               fill_cnt = 0;
  int unsigned               oldest_ptr = 0;
  int unsigned               win_sum = 0;
  logic [LW-1:0]             cur_lvl = llhm_pkg::LVL_IDLE;
  logic [SW-1:0]             last_avg = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void queue_sample(logic [SW-1:0] v);
    sample_q.insert(sample_q.size(), v);
  endfunction

  function automatic int unsigned window_span();
    int unsigned n;
    n = wl_reg;
    if (n < 1) n = 1;
    if (n > WIN_MAX) n = WIN_MAX;
    return n;
  endfunction

  function automatic longint unsigned scaled(logic [SW-1:0] r);
    if (PCT_MODE != 0) return 64'(thr_cfg.base_level) * 64'(r);
    return 64'(r) << 16;
  endfunction

  function automatic load_report_t advance_monitor(logic [SW-1:0] smp);
    int unsigned       n;
    int unsigned       slot;
    longint unsigned   avg_q;
    logic [LW-1:0]     prev;
    load_report_t      r;
    prev = cur_lvl;
    if (thr_cfg.base_level != 0) begin
      n = window_span();
      if (oldest_ptr >= n) oldest_ptr = 0;
      if (fill_cnt > n) fill_cnt = n;
      if (fill_cnt < n) begin
        slot = (oldest_ptr + fill_cnt) % n;
        win_mem[slot] = smp;
        win_sum += smp;
        fill_cnt++;
      end else begin
        win_sum -= win_mem[oldest_ptr];
        win_mem[oldest_ptr] = smp;
        win_sum += smp;
        oldest_ptr = (oldest_ptr + 1) % n;
      end
      last_avg = 16'(win_sum / n);
      avg_q = 64'(last_avg) << 16;
      case (cur_lvl)
        llhm_pkg::LVL_IDLE: begin
          if (avg_q > scaled(thr_cfg.error_level)) cur_lvl = llhm_pkg::LVL_FATAL;
          else if (avg_q > scaled(thr_cfg.warn_level)) cur_lvl = llhm_pkg::LVL_ERROR;
          else if (avg_q > scaled(thr_cfg.idle_level)) cur_lvl = llhm_pkg::LVL_WARN;
        end
        llhm_pkg::LVL_WARN: begin
          if (avg_q > scaled(thr_cfg.error_level)) cur_lvl = llhm_pkg::LVL_FATAL;
          else if (avg_q > scaled(thr_cfg.warn_level)) cur_lvl = llhm_pkg::LVL_ERROR;
          else if (avg_q <= scaled(thr_cfg.warn_release)) cur_lvl = llhm_pkg::LVL_IDLE;
        end
        llhm_pkg::LVL_ERROR: begin
          if (avg_q > scaled(thr_cfg.error_level)) cur_lvl = llhm_pkg::LVL_FATAL;
          else if (avg_q <= scaled(thr_cfg.error_release)) cur_lvl = llhm_pkg::LVL_IDLE;
        end
        default: begin
          if (avg_q <= scaled(thr_cfg.fatal_release)) cur_lvl = llhm_pkg::LVL_IDLE;
        end
      endcase
    end
    r.level   = cur_lvl;
    r.changed = (cur_lvl != prev);
    r.average = last_avg;
    return r;
  endfunction

  function automatic logic [SW-1:0] near(logic [SW-1:0] center, int spread);
    int v;
    v = int'(center) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [SW-1:0] in_load_units(logic [SW-1:0] r);
    if (PCT_MODE != 0) return 16'((32'(thr_cfg.base_level) * 32'(r)) >> 16);
    return r;
  endfunction

  task automatic write_reg(input logic [llhm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [llhm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      llhm_pkg::REG_WINDOW_LENGTH: begin
        wl_reg = data[llhm_pkg::WL_W-1:0];
        fill_cnt = 0;
        oldest_ptr = 0;
        win_sum = 0;
      end
      llhm_pkg::REG_BASE_LEVEL:    thr_cfg.base_level = data;
      llhm_pkg::REG_ERROR_LEVEL:   thr_cfg.error_level = data;
      llhm_pkg::REG_WARN_LEVEL:    thr_cfg.warn_level = data;
      llhm_pkg::REG_IDLE_LEVEL:    thr_cfg.idle_level = data;
      llhm_pkg::REG_FATAL_RELEASE: thr_cfg.fatal_release = data;
      llhm_pkg::REG_ERROR_RELEASE: thr_cfg.error_release = data;
      default:                     thr_cfg.warn_release = data;
    endcase
  endtask

  // Writes the six thresholds and closes the register write burst.
  task automatic set_levels(input logic [15:0] e, input logic [15:0] w, input logic [15:0] i,
                            input logic [15:0] fr, input logic [15:0] er,
                            input logic [15:0] wr);
    write_reg(llhm_pkg::REG_ERROR_LEVEL, e);
    write_reg(llhm_pkg::REG_WARN_LEVEL, w);
    write_reg(llhm_pkg::REG_IDLE_LEVEL, i);
    write_reg(llhm_pkg::REG_FATAL_RELEASE, fr);
    write_reg(llhm_pkg::REG_ERROR_RELEASE, er);
    write_reg(llhm_pkg::REG_WARN_RELEASE, wr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (sample_q.size() != 0 || in_valid || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (thr_cfg.base_level == 0) unarmed_cnt++;
        sample_cnt++;
        pending_reports.insert(pending_reports.size(), advance_monitor(in_sample));
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= sample_q[0];
          sample_q.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    load_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("result with no sample outstanding: level %0d average %0d",
               out_level, out_average);
        err_cnt++;
      end else begin
        want = pending_reports[0];
        pending_reports.delete(0);
        report_cnt++;
        level_seen[out_level]++;
        if (out_changed === 1'b1) change_cnt++;
        if (out_level !== want.level) begin
          $error("level mismatch: expected %0d, got %0d", want.level, out_level);
          err_cnt++;
        end
        if (out_changed !== want.changed) begin
          $error("changed mismatch: expected %0d, got %0d", want.changed, out_changed);
          err_cnt++;
        end
        if (out_average !== want.average) begin
          $error("average mismatch: expected %0d, got %0d", want.average, out_average);
          err_cnt++;
        end
      end
    end
    out_stall <= hold_on || ($urandom_range(99) < rcv_stall_pct);
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    forever begin
      wait (hold_go);
      hold_go = 1'b0;
      hold_on <= 1'b1;
      repeat (300) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          m;
    int          left;
    int          run_len;
    int          spread;
    int          items;
    logic [15:0] tgt;
    logic [15:0] t0;
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] swp;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the monitor is not armed, so samples are ignored.
    queue_sample(16'hFFFF);
    queue_sample(16'h0000);
    queue_sample(16'h1234);
    wait_quiet();

    // A window length of zero behaves as one, so each average is the sample itself.
    write_reg(llhm_pkg::REG_WINDOW_LENGTH, 16'd0);
    write_reg(llhm_pkg::REG_BASE_LEVEL, 16'h8000);
    set_levels(16'd3000, 16'd2000, 16'd1000, 16'd2500, 16'd1500, 16'd500);
    foreach (STEP_SAMPLES[i]) queue_sample(STEP_SAMPLES[i]);
    wait_quiet();

    for (int p = 0; p < N_PHASES; p++) begin
      m = p % 4;
      snd_idle_pct  = (m == 1) ? 49 : (m == 3) ? 7 : 0;
      rcv_stall_pct = (m == 2) ? 49 : (m == 3) ? 7 : 0;

      if (p != 1 && p != 4 && p != 6) write_reg(llhm_pkg::REG_WINDOW_LENGTH, WL_CHOICE[p]);
      if (p == 6) write_reg(llhm_pkg::REG_BASE_LEVEL, 16'd0);
      else if (p == 3) write_reg(llhm_pkg::REG_BASE_LEVEL, 16'hFFFF);
      else write_reg(llhm_pkg::REG_BASE_LEVEL, 16'($urandom_range(65535, 1)));

      if (p == 5) begin
        set_levels(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      end else if (p == 7) begin
        set_levels(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      end else if (p % 3 == 2) begin
        set_levels(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)));
      end else begin
        t0 = 16'($urandom_range(65535));
        t1 = 16'($urandom_range(65535));
        t2 = 16'($urandom_range(65535));
        if (t0 > t1) begin swp = t0; t0 = t1; t1 = swp; end
        if (t1 > t2) begin swp = t1; t1 = t2; t2 = swp; end
        if (t0 > t1) begin swp = t0; t0 = t1; t1 = swp; end
        set_levels(t2, t1, t0, 16'($urandom_range(t2)), 16'($urandom_range(t1)),
                   16'($urandom_range(t0)));
      end

      // Runs of samples that settle around one of the thresholds or a random level, with some noise.
      items = (p == 6) ? 24 : 68;
      left = items;
      while (left > 0) begin
        run_len = $urandom_range(2 * window_span() + 2, 1);
        case ($urandom_range(6))
          0:       tgt = in_load_units(thr_cfg.idle_level);
          1:       tgt = in_load_units(thr_cfg.warn_level);
          2:       tgt = in_load_units(thr_cfg.error_level);
          3:       tgt = in_load_units(thr_cfg.fatal_release);
          4:       tgt = in_load_units(thr_cfg.error_release);
          5:       tgt = in_load_units(thr_cfg.warn_release);
          default: tgt = 16'($urandom_range(65535));
        endcase
        spread = ($urandom_range(3) == 0) ? $urandom_range(4000) : $urandom_range(40);
        for (int i = 0; i < run_len && left > 0; i++) begin
          if ($urandom_range(9) == 0) queue_sample(16'($urandom_range(65535)));
          else queue_sample(near(tgt, spread));
          left--;
        end
      end
      if (p == 4) hold_go = 1'b1;
      wait_quiet();
    end

    $display("Checked %0d samples (%0d while unarmed) over %0d configurations,",
             sample_cnt, unarmed_cnt, N_PHASES + 2);
    $display("window lengths 0 to 63; levels idle/warn/error/fatal %0d/%0d/%0d/%0d, %0d changes.",
             level_seen[0], level_seen[1], level_seen[2], level_seen[3], change_cnt);
    if (err_cnt == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
